[src/rkrd_pkg.sv]
// ----------------------------------------------------------------------------
// rkrd_pkg
// Shared types and constants for the recent key repeat detector: value and
// word sizes, result count limits and the controller/datapath signal groups.
// ----------------------------------------------------------------------------
package rkrd_pkg;

    // Size of one checked value
    localparam int VALUE_BYTES = 32;
    localparam int VALUE_W     = 8 * VALUE_BYTES;
    localparam int WORD_W      = 64;

    // Reported entry count saturates at this value
    localparam int          HELD_W   = 7;
    localparam logic [6:0]  HELD_MAX = 7'd127;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the accepted word, restart the scan
        logic issue;    // read the next ring entry
        logic commit;   // insert on a miss and load the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic more;     // entries left to read in the scan
        logic hit_any;  // a held entry matched so far
    } status_t;

endpackage

[src/rkrd_ctrl.sv]
// ----------------------------------------------------------------------------
// rkrd_ctrl
// Controller: sequences accept, ring scan and commit, and owns the output
// valid flag so a finished result may wait while the next word is taken.
// ----------------------------------------------------------------------------
module rkrd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rkrd_pkg::status_t status,
    output rkrd_pkg::cmd_t    cmd
);
    import rkrd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Decode commands and next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = status.more && !status.hit_any;
                if (status.hit_any || !status.more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/rkrd_datapath.sv]
// ----------------------------------------------------------------------------
// rkrd_datapath
// Datapath: value register, ring memory with one registered read port, scan
// counter and comparator, write pointer, fill count and result registers.
// ----------------------------------------------------------------------------
module rkrd_datapath #(
    parameter int RING_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [63:0]            value_word_0,
    input  logic [63:0]            value_word_1,
    input  logic [63:0]            value_word_2,
    input  logic [63:0]            value_word_3,
    input  rkrd_pkg::cmd_t         cmd,
    output rkrd_pkg::status_t      status,
    output logic                   repeat_found,
    output logic [6:0]             entries_held
);
    import rkrd_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int EXT_W = (CNT_W > HELD_W) ? CNT_W : HELD_W;

    // Ring storage, contents defined only once written
    logic [VALUE_W-1:0] ring_mem [RING_DEPTH];

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               cmp_valid_reg;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               repeat_found_reg;
    logic [6:0]         entries_held_reg, held_next;
    logic [EXT_W-1:0]   fill_ext;
    logic               match;

    // Compare the entry read last cycle with the held word
    assign match          = cmp_valid_reg && (rd_data_reg == value_reg);
    assign status.hit_any = hit_reg || match;
    assign status.more    = (idx_reg < fill_reg);

    // Scan counter and hit flag
    always_comb
    begin
        idx_next = idx_reg;
        hit_next = hit_reg || match;
        if (cmd.load)
        begin
            idx_next = '0;
            hit_next = 1'b0;
        end
        else if (cmd.issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    // Insert on a miss: advance pointer modulo depth, grow fill up to depth
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (cmd.commit && !hit_reg)
        begin
            if (wp_reg == IDX_W'(RING_DEPTH - 1))
                wp_next = '0;
            else
                wp_next = wp_reg + IDX_W'(1);
            if (fill_reg < CNT_W'(RING_DEPTH))
                fill_next = fill_reg + CNT_W'(1);
        end
    end

    // Saturate the reported count
    always_comb
    begin
        fill_ext = EXT_W'(fill_next);
        if (fill_ext > EXT_W'(HELD_MAX))
            held_next = HELD_MAX;
        else
            held_next = fill_ext[HELD_W-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            wp_reg        <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmd.issue;
            hit_reg       <= hit_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
        end
    end

    // Capture the accepted word and the result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            value_reg <= {value_word_3, value_word_2, value_word_1, value_word_0};
        if (cmd.commit)
        begin
            repeat_found_reg <= hit_reg;
            entries_held_reg <= held_next;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_reg)
            ring_mem[wp_reg] <= value_reg;
        if (cmd.issue)
            rd_data_reg <= ring_mem[idx_reg[IDX_W-1:0]];
    end

    assign repeat_found = repeat_found_reg;
    assign entries_held = entries_held_reg;

endmodule

[src/recent_key_repeat_detector.sv]
// ----------------------------------------------------------------------------
// recent_key_repeat_detector
// Flags a 256-bit value that repeats one of the last RING_DEPTH distinct
// values, and otherwise records it in the ring.
// ----------------------------------------------------------------------------
// One word is taken at a time. The scan reads ring entries up to and including
// the matching entry on a repeat, or every held entry (at most RING_DEPTH) on
// a miss. The ring sits in a single memory with one registered read port, so
// the scan reads one entry per cycle; the last compare is then finished from
// the registered read data, and a commit step inserts the word on a miss and
// loads the result register. The next word can be taken in the cycle after
// the commit. A finished result waits in its output register while the next
// word is accepted and scanned; the commit of that next word waits until the
// previous result has been taken. The ring needs no clearing after reset;
// only entries already written are read. entries_held saturates at 127.
// ----------------------------------------------------------------------------
module recent_key_repeat_detector #(
    parameter int RING_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value_word_0,
    input  logic [63:0] value_word_1,
    input  logic [63:0] value_word_2,
    input  logic [63:0] value_word_3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        repeat_found,
    output logic [6:0]  entries_held
);
    import rkrd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence the scan
    rkrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the ring and compare
    rkrd_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_word_0 (value_word_0),
        .value_word_1 (value_word_1),
        .value_word_2 (value_word_2),
        .value_word_3 (value_word_3),
        .cmd          (cmd),
        .status       (status),
        .repeat_found (repeat_found),
        .entries_held (entries_held)
    );

endmodule

[src/rkrd_checker.sv]
// ----------------------------------------------------------------------------
// rkrd_checker
// Port-level checks for the recent key repeat detector, bound to the top.
// ----------------------------------------------------------------------------
module rkrd_checker #(
    parameter int RING_DEPTH = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       repeat_found,
    input logic [6:0] entries_held
);

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(repeat_found)
                                    && $stable(entries_held))
        else $error("result changed while stalled");

    // One word at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word accepted while previous scan busy");

    // The first word is always inserted, so a result never shows an empty ring
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entries_held != 7'd0)
        else $error("result reports empty ring");

    // The count never exceeds the ring depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(entries_held) <= RING_DEPTH)
        else $error("entry count above ring depth");

endmodule

bind recent_key_repeat_detector rkrd_checker #(
    .RING_DEPTH (RING_DEPTH)
) u_rkrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .repeat_found (repeat_found),
    .entries_held (entries_held)
);
